// ===== rtl/fmbq_pkg.sv =====
`timescale 1ns / 1ps

package fmbq_pkg;

  // Request codes; codes 6 and 7 carry no meaning and are ignored
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT  = 3'd0,
    REQ_PUSH_MIDDLE = 3'd1,
    REQ_PUSH_BACK   = 3'd2,
    REQ_POP_FRONT   = 3'd3,
    REQ_POP_MIDDLE  = 3'd4,
    REQ_POP_BACK    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 7;

  localparam logic signed [VALUE_W-1:0] POP_EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [2:0]                 req_type;
    logic signed [VALUE_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  pop_value;
    status_t                    status;
    logic [OCC_W-1:0]           occupancy;
  } out_item_t;

endpackage

// ===== rtl/fmbq_ram.sv =====
`timescale 1ns / 1ps

module fmbq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/front_middle_back_queue.sv =====
`timescale 1ns / 1ps
// A request transfers in from the idle state, where both half-queue memories are read; the exec
// state then writes back, updates the counts and registers the result, holding while the previous
// result is stalled downstream. A new request is taken only after the exec state has finished.
// The output register lets the next request transfer in while a result is still waiting.
// Reset (rst_n, synchronous, active low) empties the queue; memory contents are not cleared.
module front_middle_back_queue #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmbq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fmbq_pkg::out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  // Circular slot helpers for a half queue of CAPACITY entries
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(off);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] x);
    return (x == '0) ? AW'(CAPACITY - 1) : x - 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] x);
    return (SW'(x) + 1'b1 >= SW'(CAPACITY)) ? '0 : x + 1'b1;
  endfunction

  // Control state
  fmbq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    fh_r, fh_nxt, bh_r, bh_nxt;
  logic [CW-1:0]    fc_r, fc_nxt, bc_r, bc_nxt;
  logic             out_valid_r;

  // Captured request
  logic [2:0]            req_r;
  logic [DATA_WIDTH-1:0] val_r;
  fmbq_pkg::out_item_t   out_data_r, out_nxt;

  logic in_xfer, exec_go;

  // Memory ports
  logic [AW-1:0]         f_rd_addr, b_rd_addr, fw_addr, bw_addr;
  logic [DATA_WIDTH-1:0] f_rd, b_rd, fw_data, bw_data;
  logic                  fw_en, bw_en;

  // Slot positions from the current heads and counts
  logic [AW-1:0] f_last, f_tail, f_dec, f_inc, b_last, b_tail, b_dec, b_inc;
  logic [CW-1:0] tot, tot_nxt;
  logic          halves_eq;

  logic [DATA_WIDTH-1:0] pop_data;
  logic                  popped;
  fmbq_pkg::status_t     status;

  assign f_last    = slot_add(fh_r, CW'(fc_r - 1'b1));
  assign f_tail    = slot_add(fh_r, fc_r);
  assign f_dec     = slot_dec(fh_r);
  assign f_inc     = slot_inc(fh_r);
  assign b_last    = slot_add(bh_r, CW'(bc_r - 1'b1));
  assign b_tail    = slot_add(bh_r, bc_r);
  assign b_dec     = slot_dec(bh_r);
  assign b_inc     = slot_inc(bh_r);
  assign tot       = CW'(fc_r + bc_r);
  assign halves_eq = (fc_r == bc_r);

  // ---------------------------------------------------------------------------
  // Sequencer: idle takes a transfer and issues both reads; exec writes back.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fmbq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = fmbq_pkg::S_EXEC;
        end
      end
      fmbq_pkg::S_EXEC: begin
        // Hold while the previous result still waits downstream
        if (!(out_valid_r && out_stall)) begin
          state_nxt = fmbq_pkg::S_IDLE;
        end
      end
      default: state_nxt = fmbq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != fmbq_pkg::S_IDLE);
    exec_go  = (state_r == fmbq_pkg::S_EXEC) && !(out_valid_r && out_stall);
  end

  assign in_xfer = in_valid && !in_stall;

  // Read addresses: the front half is read at its head for a front pop and at its
  // last element otherwise; the back half at its last element for a back pop and
  // at its head otherwise. Every request needs at most these two values.
  always_comb begin
    f_rd_addr = (in_data.req_type == fmbq_pkg::REQ_POP_FRONT) ? fh_r : f_last;
    b_rd_addr = (in_data.req_type == fmbq_pkg::REQ_POP_BACK)  ? b_last : bh_r;
  end

  fmbq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_front_ram (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (f_rd_addr),
    .rd_data (f_rd),
    .wr_en   (fw_en),
    .wr_addr (fw_addr),
    .wr_data (fw_data)
  );

  fmbq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_back_ram (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd),
    .wr_en   (bw_en),
    .wr_addr (bw_addr),
    .wr_data (bw_data)
  );

  // ---------------------------------------------------------------------------
  // Update: the request plus the rebalancing move, folded into at most one write
  // per half. The front half always holds as many elements as the back half or
  // one more, so the middle is the last element of the front half.
  // ---------------------------------------------------------------------------
  always_comb begin
    fh_nxt   = fh_r;
    fc_nxt   = fc_r;
    bh_nxt   = bh_r;
    bc_nxt   = bc_r;
    fw_en    = 1'b0;
    fw_addr  = f_tail;
    fw_data  = val_r;
    bw_en    = 1'b0;
    bw_addr  = b_tail;
    bw_data  = val_r;
    pop_data = f_rd;
    popped   = 1'b0;
    status   = fmbq_pkg::ST_OK;

    if (exec_go) begin
      unique case (req_r)
        fmbq_pkg::REQ_PUSH_FRONT: begin
          if (tot >= CW'(CAPACITY)) begin
            status = fmbq_pkg::ST_FULL;
          end else begin
            fw_en   = 1'b1;
            fw_addr = f_dec;
            fw_data = val_r;
            fh_nxt  = f_dec;
            if (halves_eq) begin
              fc_nxt = CW'(fc_r + 1'b1);
            end else begin
              // Front half would be two ahead: move its last element across
              bw_en   = 1'b1;
              bw_addr = b_dec;
              bw_data = f_rd;
              bh_nxt  = b_dec;
              bc_nxt  = CW'(bc_r + 1'b1);
            end
          end
        end
        fmbq_pkg::REQ_PUSH_MIDDLE: begin
          if (tot >= CW'(CAPACITY)) begin
            status = fmbq_pkg::ST_FULL;
          end else if (halves_eq) begin
            fw_en   = 1'b1;
            fw_addr = f_tail;
            fw_data = val_r;
            fc_nxt  = CW'(fc_r + 1'b1);
          end else begin
            // Old middle moves to the back half; the new value takes its slot
            fw_en   = 1'b1;
            fw_addr = f_last;
            fw_data = val_r;
            bw_en   = 1'b1;
            bw_addr = b_dec;
            bw_data = f_rd;
            bh_nxt  = b_dec;
            bc_nxt  = CW'(bc_r + 1'b1);
          end
        end
        fmbq_pkg::REQ_PUSH_BACK: begin
          if (tot >= CW'(CAPACITY)) begin
            status = fmbq_pkg::ST_FULL;
          end else if (halves_eq) begin
            // Back half's head moves to the front half's tail; with an empty back
            // half the pushed value goes straight there
            fw_en   = 1'b1;
            fw_addr = f_tail;
            fc_nxt  = CW'(fc_r + 1'b1);
            if (bc_r == '0) begin
              fw_data = val_r;
            end else begin
              fw_data = b_rd;
              bw_en   = 1'b1;
              bw_addr = b_tail;
              bw_data = val_r;
              bh_nxt  = b_inc;
            end
          end else begin
            bw_en   = 1'b1;
            bw_addr = b_tail;
            bw_data = val_r;
            bc_nxt  = CW'(bc_r + 1'b1);
          end
        end
        fmbq_pkg::REQ_POP_FRONT: begin
          if (tot == '0) begin
            status = fmbq_pkg::ST_EMPTY;
          end else begin
            popped   = 1'b1;
            pop_data = f_rd;
            fh_nxt   = f_inc;
            if (halves_eq) begin
              fw_en   = 1'b1;
              fw_addr = f_tail;
              fw_data = b_rd;
              bh_nxt  = b_inc;
              bc_nxt  = CW'(bc_r - 1'b1);
            end else begin
              fc_nxt = CW'(fc_r - 1'b1);
            end
          end
        end
        fmbq_pkg::REQ_POP_MIDDLE: begin
          if (tot == '0) begin
            status = fmbq_pkg::ST_EMPTY;
          end else begin
            popped   = 1'b1;
            pop_data = f_rd;
            if (halves_eq) begin
              // Back half's head refills the vacated middle slot
              fw_en   = 1'b1;
              fw_addr = f_last;
              fw_data = b_rd;
              bh_nxt  = b_inc;
              bc_nxt  = CW'(bc_r - 1'b1);
            end else begin
              fc_nxt = CW'(fc_r - 1'b1);
            end
          end
        end
        fmbq_pkg::REQ_POP_BACK: begin
          if (tot == '0) begin
            status = fmbq_pkg::ST_EMPTY;
          end else if (bc_r == '0) begin
            // Single element, held in the front half
            popped   = 1'b1;
            pop_data = f_rd;
            fc_nxt   = CW'(fc_r - 1'b1);
          end else begin
            popped   = 1'b1;
            pop_data = b_rd;
            if (halves_eq) begin
              bc_nxt = CW'(bc_r - 1'b1);
            end else begin
              // Front half would be two ahead: its last element crosses over
              bw_en   = 1'b1;
              bw_addr = b_dec;
              bw_data = f_rd;
              bh_nxt  = b_dec;
              fc_nxt  = CW'(fc_r - 1'b1);
            end
          end
        end
        default: begin
          // Unused codes: drop the request, report the unchanged occupancy
        end
      endcase
    end

    tot_nxt = CW'(fc_nxt + bc_nxt);

    out_nxt.status    = status;
    out_nxt.occupancy = fmbq_pkg::OCC_W'(tot_nxt);
    if (status == fmbq_pkg::ST_EMPTY) begin
      out_nxt.pop_value = fmbq_pkg::POP_EMPTY_VALUE;
    end else if (popped) begin
      out_nxt.pop_value = fmbq_pkg::VALUE_W'($signed(pop_data));
    end else begin
      out_nxt.pop_value = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmbq_pkg::S_IDLE;
      fh_r        <= '0;
      fc_r        <= '0;
      bh_r        <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fh_r    <= fh_nxt;
      fc_r    <= fc_nxt;
      bh_r    <= bh_nxt;
      bc_r    <= bc_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request on transfer; only the low DATA_WIDTH bits are stored
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data.req_type;
      val_r <= DATA_WIDTH'($unsigned(in_data.push_value));
    end
    if (exec_go) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/front_middle_back_queue_test.sv =====
`timescale 1ns / 1ps

module front_middle_back_queue_test;
  import fmbq_pkg::*;

  // Queue depth the block is built with; the predictor uses the same bound
  localparam int DEPTH = 64;

  // Codes the block must ignore: no change, zero value, OK status
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  // Cycles without any transfer on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int SEGMENT_LEN = 120;

  // Shadow of the queue: the two halves as the block keeps them, and the
  // results still owed by the block, oldest first.
  class fmbq_shadow;
    logic [VALUE_W-1:0] front_half[$];
    logic [VALUE_W-1:0] back_half[$];
    out_item_t owed_results[$];
    int errors = 0;
    int pushes = 0;
    int pops = 0;
    int empty_pops = 0;
    int full_pushes = 0;
    int ignored = 0;
    int results = 0;
    int peak = 0;

    // Keep the front half equal to the back half or one larger
    function void rebalance();
      if (front_half.size() < back_half.size()) begin
        front_half.insert(front_half.size(), back_half[0]);
        back_half.delete(0);
      end
      if (front_half.size() == back_half.size() + 2) begin
        back_half.insert(0, front_half[$]);
        front_half.delete(front_half.size() - 1);
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t res;
      int total;
      total = front_half.size() + back_half.size();
      res.pop_value = '0;
      res.status = ST_OK;
      case (req.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_MIDDLE, REQ_PUSH_BACK: begin
          if (total >= DEPTH) begin
            res.status = ST_FULL;
            full_pushes++;
          end else begin
            pushes++;
            if (req.req_type == REQ_PUSH_FRONT) begin
              front_half.insert(0, req.push_value);
            end else if (req.req_type == REQ_PUSH_MIDDLE) begin
              // odd count: hand the old middle to the back half first
              if (front_half.size() > back_half.size()) begin
                back_half.insert(0, front_half[$]);
                front_half.delete(front_half.size() - 1);
              end
              front_half.insert(front_half.size(), req.push_value);
            end else begin
              back_half.insert(back_half.size(), req.push_value);
            end
            rebalance();
          end
        end
        REQ_POP_FRONT, REQ_POP_MIDDLE, REQ_POP_BACK: begin
          if (total == 0) begin
            res.pop_value = POP_EMPTY_VALUE;
            res.status = ST_EMPTY;
            empty_pops++;
          end else begin
            pops++;
            if (req.req_type == REQ_POP_FRONT) begin
              res.pop_value = front_half[0];
              front_half.delete(0);
            end else if (req.req_type == REQ_POP_MIDDLE || back_half.size() == 0) begin
              res.pop_value = front_half[$];
              front_half.delete(front_half.size() - 1);
            end else begin
              res.pop_value = back_half[$];
              back_half.delete(back_half.size() - 1);
            end
            rebalance();
          end
        end
        default: ignored++;
      endcase
      res.occupancy = OCC_W'(front_half.size() + back_half.size());
      if (res.occupancy > peak)
        peak = res.occupancy;
      owed_results.insert(owed_results.size(), res);
    endfunction

    function void report(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %0h", $time, got);
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      if (got.pop_value !== want.pop_value)
        report("pop_value", want.pop_value, got.pop_value);
      if (got.status !== want.status)
        report("status", VALUE_W'(want.status), VALUE_W'(got.status));
      if (got.occupancy !== want.occupancy)
        report("occupancy", VALUE_W'(want.occupancy), VALUE_W'(got.occupancy));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // Idle odds in percent; the sender's is read only by the stimulus process,
  // the receiver's is changed with a nonblocking write
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  fmbq_shadow shadow;

  front_middle_back_queue #(
    .CAPACITY   (DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Result side: check every transfer, then pick the stall for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      shadow.check_result(out_data);
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: count edges on which neither channel transfers
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("front_middle_back_queue_test failed");
        $finish;
      end
    end
  end

  function automatic in_item_t make_req(input logic [2:0] code, input logic [VALUE_W-1:0] value);
    in_item_t item;
    item.req_type = code;
    item.push_value = value;
    return item;
  endfunction

  // Favour the extremes of the value range now and then
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Hold the request until it transfers, idling first at the sender's odds;
  // predict its result at the transfer edge
  task automatic send(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    shadow.note_request(item);
  endtask

  // Ignored codes are sent now and then but do not count as items
  task automatic send_random(input int push_pct, output bit counted);
    int roll;
    logic [2:0] code;
    roll = $urandom_range(99);
    counted = 1'b1;
    if (roll < 3) begin
      code = (roll == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
      counted = 1'b0;
    end else if ($urandom_range(99) < push_pct) begin
      case ($urandom_range(2))
        0: code = REQ_PUSH_FRONT;
        1: code = REQ_PUSH_MIDDLE;
        default: code = REQ_PUSH_BACK;
      endcase
    end else begin
      case ($urandom_range(2))
        0: code = REQ_POP_FRONT;
        1: code = REQ_POP_MIDDLE;
        default: code = REQ_POP_BACK;
      endcase
    end
    send(make_req(code, pick_value()));
  endtask

  // Drop valid and wait for every owed result; always advance at least one edge
  task automatic drain();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (shadow.owed_results.size() != 0);
  endtask

  initial begin
    int sent;
    int push_pct;
    bit counted;
    shadow = new();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every pop on an empty queue, the ignored codes, the value
    // extremes, middle pushes on odd and even counts, and a pop at the back
    // when only the front half holds anything
    send(make_req(REQ_POP_FRONT, 32'h1234_5678));
    send(make_req(REQ_POP_MIDDLE, '1));
    send(make_req(REQ_POP_BACK, '0));
    send(make_req(REQ_SPARE_6, 32'h5a5a_5a5a));
    send(make_req(REQ_SPARE_7, 32'ha5a5_a5a5));
    send(make_req(REQ_PUSH_BACK, 32'h7fff_ffff));
    send(make_req(REQ_PUSH_FRONT, 32'h8000_0000));
    send(make_req(REQ_PUSH_MIDDLE, '0));
    send(make_req(REQ_PUSH_MIDDLE, '1));
    send(make_req(REQ_PUSH_MIDDLE, 32'h5555_5555));
    send(make_req(REQ_SPARE_6, '0));
    send(make_req(REQ_POP_MIDDLE, '0));
    send(make_req(REQ_POP_MIDDLE, '1));
    send(make_req(REQ_POP_BACK, '0));
    send(make_req(REQ_POP_FRONT, '0));
    send(make_req(REQ_POP_BACK, '0));
    send(make_req(REQ_POP_BACK, '0));
    send(make_req(REQ_PUSH_FRONT, 32'haaaa_aaaa));
    send(make_req(REQ_POP_MIDDLE, '0));
    send(make_req(REQ_PUSH_BACK, 32'h0000_0001));
    send(make_req(REQ_POP_FRONT, '0));
    drain();

    // Random: four handshake phases, each cycling through a filling stretch
    // that runs into the full queue, a draining one that empties it, and churn
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        case ((sent / SEGMENT_LEN) % 3)
          0: push_pct = 88;
          1: push_pct = 12;
          default: push_pct = 50;
        endcase
        send_random(push_pct, counted);
        sent += counted;
      end
      drain();
    end

    // Settle well past the block's result latency to catch stray results
    repeat (8) @(posedge clk);

    $display("Covered %0d pushes, %0d pops, %0d pops on empty, %0d pushes on full, %0d ignored",
             shadow.pushes, shadow.pops, shadow.empty_pops, shadow.full_pushes, shadow.ignored);
    $display("Checked %0d results across four handshake phases, peak occupancy %0d of %0d",
             shadow.results, shadow.peak, DEPTH);
    if (shadow.errors == 0 && shadow.owed_results.size() == 0)
      $display("front_middle_back_queue_test passed");
    else
      $display("front_middle_back_queue_test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fmbq_pkg.sv
rtl/fmbq_ram.sv
rtl/front_middle_back_queue.sv
sim/front_middle_back_queue_test.sv
